@@ rtl/wsr_pkg.sv @@
`default_nettype none

package wsr_pkg;

    localparam int CFG_W = 6;
    localparam int POS_W = 5;
    localparam int MASK_W = 32;
    localparam int RANK_W = 28;
    localparam int D_W = 8;
    localparam int KMAX = 32;
    localparam int D_ROWS = 64;

    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    typedef logic [KMAX:0][RANK_W-1:0] pascal_row_t;
    typedef pascal_row_t [D_ROWS-1:0] row_table_t;

    // Control that travels with each transaction down the row of cells.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] erased_first;
        logic [POS_W-1:0] erased_second;
        logic [D_W-1:0]   d;
    } stage_ctl_t;

    function automatic logic [RANK_W-1:0] sat_add(
        input logic [RANK_W-1:0] a,
        input logic [RANK_W-1:0] b
    );
        logic [RANK_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[RANK_W] ? RANK_MAX : s[RANK_W-1:0];
        end
    endfunction

    // Rows of Pascal's triangle, saturated at the largest rank.
    function automatic row_table_t build_row_table();
        row_table_t      tbl;
        pascal_row_t     cur;
        logic [RANK_W:0] s;
        begin
            cur = '0;
            cur[0] = RANK_W'(1);
            for (int n = 0; n < D_ROWS; n++)
            begin
                tbl[n] = cur;
                for (int j = KMAX; j >= 1; j--)
                begin
                    s = {1'b0, cur[j]} + {1'b0, cur[j-1]};
                    cur[j] = s[RANK_W] ? RANK_MAX : s[RANK_W-1:0];
                end
            end
            build_row_table = tbl;
        end
    endfunction

    localparam row_table_t ROW_TABLE = build_row_table();

endpackage

`default_nettype wire

@@ rtl/wsr_front.sv @@
`default_nettype none

module wsr_front #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  advance,
    input  wire logic                                  in_valid,
    input  wire logic [wsr_pkg::CFG_W-1:0]             width_in_use,
    input  wire logic [wsr_pkg::CFG_W-1:0]             window_length,
    input  wire logic                                  op,
    input  wire logic [wsr_pkg::MASK_W-1:0]            support_mask,
    input  wire logic [wsr_pkg::POS_W-1:0]             missing_position,
    input  wire logic [wsr_pkg::POS_W-1:0]             window_low,
    input  wire logic [wsr_pkg::POS_W-1:0]             erased_first,
    input  wire logic [wsr_pkg::POS_W-1:0]             erased_second,
    output wsr_pkg::stage_ctl_t                        ctl_out,
    output logic [MAX_WIDTH-1:0]                       mask_out,
    output logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]    row_out
);

    localparam logic [wsr_pkg::CFG_W-1:0] MAXW = wsr_pkg::CFG_W'(MAX_WIDTH);

    logic [wsr_pkg::CFG_W-1:0]                w_eff;
    logic [wsr_pkg::CFG_W-1:0]                bit_count;
    logic [MAX_WIDTH-1:0]                     mask_valid;
    logic [MAX_WIDTH-1:0]                     full_mask;
    logic [MAX_WIDTH-1:0]                     shifted;
    logic [MAX_WIDTH-1:0]                     window_mask;
    logic [wsr_pkg::CFG_W-1:0]                ea6;
    logic [wsr_pkg::CFG_W-1:0]                eb6;
    logic [wsr_pkg::CFG_W-1:0]                miss6;
    logic                                     below_a;
    logic                                     below_b;
    logic                                     both_top;
    logic [wsr_pkg::D_W-1:0]                  d_start;
    logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]  row_start;

    wsr_pkg::stage_ctl_t                      ctl_reg;
    wsr_pkg::stage_ctl_t                      ctl_next;
    logic [MAX_WIDTH-1:0]                     mask_reg;
    logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]  row_reg;

    assign ea6 = {1'b0, erased_first};
    assign eb6 = {1'b0, erased_second};
    assign miss6 = {1'b0, missing_position};

    assign w_eff = (width_in_use > MAXW) ? MAXW : width_in_use;

    always_comb
    begin
        if (op)
        begin
            bit_count = (w_eff == '0) ? '0 : w_eff - 1'b1;
        end
        else
        begin
            bit_count = w_eff;
        end
    end

    // In compressed mode a zero is inserted at the missing position.
    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            mask_valid[i] = support_mask[i] & (wsr_pkg::CFG_W'(i) < bit_count);
        end
        for (int f = 0; f < MAX_WIDTH; f++)
        begin
            if (!op || (wsr_pkg::CFG_W'(f) < miss6))
            begin
                full_mask[f] = mask_valid[f];
            end
            else if (wsr_pkg::CFG_W'(f) == miss6)
            begin
                full_mask[f] = 1'b0;
            end
            else
            begin
                full_mask[f] = mask_valid[(f > 0) ? f - 1 : 0];
            end
        end
    end

    assign shifted = full_mask >> window_low;

    always_comb
    begin
        for (int p = 0; p < MAX_WIDTH; p++)
        begin
            window_mask[p] = shifted[p]
                & (wsr_pkg::CFG_W'(p) < window_length)
                & (wsr_pkg::CFG_W'(p) != ea6)
                & (wsr_pkg::CFG_W'(p) != eb6);
        end
    end

    // The first cell steps the Pascal row from the position just above the top.
    assign below_a = ea6 < MAXW;
    assign below_b = eb6 < MAXW;
    assign both_top = (ea6 == eb6) && (ea6 == MAXW);

    assign d_start = wsr_pkg::D_W'(window_length) - wsr_pkg::D_W'(3)
        - wsr_pkg::D_W'(MAX_WIDTH) + wsr_pkg::D_W'(below_a)
        + wsr_pkg::D_W'(below_b) + wsr_pkg::D_W'(both_top);

    always_comb
    begin
        if (d_start[wsr_pkg::D_W-1])
        begin
            row_start = '0;
        end
        else
        begin
            row_start = wsr_pkg::ROW_TABLE[d_start[5:0]][MAX_WIDTH:0];
        end
    end

    always_comb
    begin
        ctl_next.valid = in_valid;
        ctl_next.erased_first = erased_first;
        ctl_next.erased_second = erased_second;
        ctl_next.d = d_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= window_mask;
            row_reg <= row_start;
        end
    end

    assign ctl_out = ctl_reg;
    assign mask_out = mask_reg;
    assign row_out = row_reg;

endmodule

`default_nettype wire

@@ rtl/wsr_cell.sv @@
`default_nettype none

module wsr_cell #(
    parameter int MAX_WIDTH = 32,
    parameter int POS = 0,
    parameter int SEEN_W = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  advance,
    input  wire wsr_pkg::stage_ctl_t                   ctl_in,
    input  wire logic [MAX_WIDTH-1:0]                  mask_in,
    input  wire logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0] row_in,
    input  wire logic [SEEN_W-1:0]                     seen_in,
    input  wire logic [wsr_pkg::RANK_W-1:0]            sum_in,
    output wsr_pkg::stage_ctl_t                        ctl_out,
    output logic [MAX_WIDTH-1:0]                       mask_out,
    output logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]    row_out,
    output logic [SEEN_W-1:0]                          seen_out,
    output logic [wsr_pkg::RANK_W-1:0]                 sum_out
);

    localparam logic [wsr_pkg::CFG_W-1:0] HERE = wsr_pkg::CFG_W'(POS);
    localparam logic [wsr_pkg::CFG_W-1:0] ABOVE = wsr_pkg::CFG_W'(POS + 1);

    logic [wsr_pkg::CFG_W-1:0]                ea6;
    logic [wsr_pkg::CFG_W-1:0]                eb6;
    logic                                     inc;
    logic                                     d_minus_one;
    logic                                     hit;
    logic [SEEN_W-1:0]                        k;
    logic [wsr_pkg::RANK_W-1:0]               term;
    logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]  row_next;

    wsr_pkg::stage_ctl_t                      ctl_reg;
    wsr_pkg::stage_ctl_t                      ctl_next;
    logic [MAX_WIDTH-1:0]                     mask_reg;
    logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]  row_reg;
    logic [SEEN_W-1:0]                        seen_reg;
    logic [SEEN_W-1:0]                        seen_next;
    logic [wsr_pkg::RANK_W-1:0]               sum_reg;
    logic [wsr_pkg::RANK_W-1:0]               sum_next;

    assign ea6 = {1'b0, ctl_in.erased_first};
    assign eb6 = {1'b0, ctl_in.erased_second};

    // The compact position rises by one per step, except past an erased position.
    assign inc = !((ea6 == HERE) || (eb6 == HERE) || ((ea6 == eb6) && (ea6 == ABOVE)));
    assign d_minus_one = (ctl_in.d == {wsr_pkg::D_W{1'b1}});

    always_comb
    begin
        row_next = row_in;
        if (inc)
        begin
            if (d_minus_one)
            begin
                row_next = '0;
                row_next[0] = wsr_pkg::RANK_W'(1);
            end
            else
            begin
                for (int j = 1; j <= MAX_WIDTH; j++)
                begin
                    row_next[j] = wsr_pkg::sat_add(row_in[j], row_in[j-1]);
                end
            end
        end
    end

    assign hit = mask_in[POS];
    assign k = seen_in + 1'b1;
    assign term = row_next[k];

    assign sum_next = hit ? wsr_pkg::sat_add(sum_in, term) : sum_in;
    assign seen_next = seen_in + SEEN_W'(hit);

    always_comb
    begin
        ctl_next = ctl_in;
        ctl_next.d = ctl_in.d + wsr_pkg::D_W'(inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= mask_in;
            row_reg <= row_next;
            seen_reg <= seen_next;
            sum_reg <= sum_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign mask_out = mask_reg;
    assign row_out = row_reg;
    assign seen_out = seen_reg;
    assign sum_out = sum_reg;

    a_neg_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.valid && ctl_reg.d[wsr_pkg::D_W-1]) |-> (row_reg == '0))
        else $error("Pascal row is not empty below row zero");

    a_row_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.valid && !ctl_reg.d[wsr_pkg::D_W-1]) |-> (row_reg[0] == wsr_pkg::RANK_W'(1)))
        else $error("Pascal row does not start with one");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.valid |-> (seen_reg <= SEEN_W'(MAX_WIDTH - POS)))
        else $error("Counted bits exceed the positions scanned");

endmodule

`default_nettype wire

@@ rtl/windowed_subset_rank.sv @@
// Windowed subset rank: combinatorial-number-system rank of the set bits of a
// support mask that fall inside a window, with two window positions erased.
// Input channel: in_valid / in_stall carries op, support_mask, missing_position,
// window_low, erased_first and erased_second; a transaction completes when
// in_valid is high and in_stall is low. Output channel: out_valid / out_stall
// carries rank, one result per input transaction, in order.
// Configuration: cfg_valid / cfg_ready writes width_in_use (index 0) or
// window_length (index 1); cfg_ready is always high. Write only when idle.
// The pipeline is one front stage that aligns the mask to the window and looks
// up the first Pascal row, then one cell per bit position.
// Throughput is one transaction per cycle while the output is not stalled;
// each cell steps its Pascal row and adds one binomial term.
// Reset empties the pipeline and sets width_in_use to 28, window_length to 15.
// While a result waits on a stalled output, the whole row of cells holds and
// in_stall is raised in the same cycle.

`default_nettype none

module windowed_subset_rank #(
    parameter int MAX_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             op,
    input  wire logic [wsr_pkg::MASK_W-1:0]       support_mask,
    input  wire logic [wsr_pkg::POS_W-1:0]        missing_position,
    input  wire logic [wsr_pkg::POS_W-1:0]        window_low,
    input  wire logic [wsr_pkg::POS_W-1:0]        erased_first,
    input  wire logic [wsr_pkg::POS_W-1:0]        erased_second,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [wsr_pkg::RANK_W-1:0]            rank,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [wsr_pkg::CFG_W-1:0]        cfg_data
);

    localparam int SEEN_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [0:0] {
        CFG_WIDTH_IN_USE  = 1'b0,
        CFG_WINDOW_LENGTH = 1'b1
    } cfg_index_t;

    logic                                     advance;
    logic [wsr_pkg::CFG_W-1:0]                width_in_use_reg;
    logic [wsr_pkg::CFG_W-1:0]                width_in_use_next;
    logic [wsr_pkg::CFG_W-1:0]                window_length_reg;
    logic [wsr_pkg::CFG_W-1:0]                window_length_next;

    wsr_pkg::stage_ctl_t                      ctl_chain  [MAX_WIDTH+1];
    logic [MAX_WIDTH-1:0]                     mask_chain [MAX_WIDTH+1];
    logic [MAX_WIDTH:0][wsr_pkg::RANK_W-1:0]  row_chain  [MAX_WIDTH+1];
    logic [SEEN_W-1:0]                        seen_chain [MAX_WIDTH+1];
    logic [wsr_pkg::RANK_W-1:0]               sum_chain  [MAX_WIDTH+1];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_in_use_next = width_in_use_reg;
        window_length_next = window_length_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WIDTH_IN_USE:  width_in_use_next = cfg_data;
                CFG_WINDOW_LENGTH: window_length_next = cfg_data;
                default:           width_in_use_next = width_in_use_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_in_use_reg <= wsr_pkg::CFG_W'(28);
            window_length_reg <= wsr_pkg::CFG_W'(15);
        end
        else
        begin
            width_in_use_reg <= width_in_use_next;
            window_length_reg <= window_length_next;
        end
    end

    assign advance = !out_valid || !out_stall;
    assign in_stall = !advance;

    wsr_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .in_valid         (in_valid),
        .width_in_use     (width_in_use_reg),
        .window_length    (window_length_reg),
        .op               (op),
        .support_mask     (support_mask),
        .missing_position (missing_position),
        .window_low       (window_low),
        .erased_first     (erased_first),
        .erased_second    (erased_second),
        .ctl_out          (ctl_chain[0]),
        .mask_out         (mask_chain[0]),
        .row_out          (row_chain[0])
    );

    assign seen_chain[0] = '0;
    assign sum_chain[0] = '0;

    // Cells run from the most significant window position down to position zero.
    for (genvar i = 0; i < MAX_WIDTH; i++)
    begin : g_cell
        wsr_cell #(
            .MAX_WIDTH (MAX_WIDTH),
            .POS       (MAX_WIDTH - 1 - i),
            .SEEN_W    (SEEN_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .ctl_in   (ctl_chain[i]),
            .mask_in  (mask_chain[i]),
            .row_in   (row_chain[i]),
            .seen_in  (seen_chain[i]),
            .sum_in   (sum_chain[i]),
            .ctl_out  (ctl_chain[i+1]),
            .mask_out (mask_chain[i+1]),
            .row_out  (row_chain[i+1]),
            .seen_out (seen_chain[i+1]),
            .sum_out  (sum_chain[i+1])
        );
    end

    assign out_valid = ctl_chain[MAX_WIDTH].valid;
    assign rank = sum_chain[MAX_WIDTH];

endmodule

`default_nettype wire
